// ===== rtl/sha_pkg.sv =====
package sha_pkg;

	localparam int CMD_DEPTH = 4;
	localparam int MSG_W     = 61;

	typedef enum logic [1:0] {
		CMD_APPEND   = 2'd0,
		CMD_FINISH   = 2'd1,
		CMD_OVERFLOW = 2'd2
	} cmd_kind_t;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_OVERFLOW = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
		logic        status;
	} out_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data_byte;
	} cmd_t;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] KROUND [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

// ===== rtl/sha_front.sv =====
module sha_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  sha_pkg::in_t  item,
	input  logic          q_full,
	output logic          q_wr,
	output sha_pkg::cmd_t q_cmd
);

	logic [sha_pkg::MSG_W-1:0] count_q;
	logic                      at_limit;

	assign full     = q_full;
	assign q_wr     = push && !q_full;
	assign at_limit = &count_q;

	always_comb begin
		q_cmd.data_byte = item.data_byte;
		if (item.op == sha_pkg::OP_FINISH) begin
			q_cmd.kind = sha_pkg::CMD_FINISH;
		end else if (at_limit) begin
			q_cmd.kind = sha_pkg::CMD_OVERFLOW;
		end else begin
			q_cmd.kind = sha_pkg::CMD_APPEND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (q_wr) begin
			if (item.op == sha_pkg::OP_FINISH) begin
				count_q <= '0;
			end else if (!at_limit) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/sha_cmdq.sv =====
module sha_cmdq #(
	parameter int Depth = sha_pkg::CMD_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  sha_pkg::cmd_t wr_cmd,
	output logic          q_full,
	output logic          rd_valid,
	input  logic          rd,
	output sha_pkg::cmd_t rd_cmd
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	sha_pkg::cmd_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          do_wr, do_rd;

	assign q_full   = (cnt_q == (AW+1)'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd   = mem_q[rp_q];
	assign do_wr    = wr && !q_full;
	assign do_rd    = rd && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/sha_back.sv =====
module sha_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cq_valid,
	input  sha_pkg::cmd_t cq_cmd,
	output logic          cq_rd,
	output logic          empty,
	input  logic          pop,
	output sha_pkg::out_t result
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_LEN, ST_COMP, ST_FF, ST_OUT
	} state_t;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

	state_t      state_q, ret_q;
	logic [5:0]  cnt_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        first_q;
	logic        ovalid_q;
	logic [sha_pkg::MSG_W-1:0] msg_q;
	logic [63:0] len_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] win_q [16];
	logic [23:0] word_q;
	sha_pkg::out_t out_q;

	logic        push_en, out_free, load_stat;
	logic [7:0]  pb;
	logic [31:0] t1, t2, wnew, s0, s1;

	assign out_free = !ovalid_q || pop;
	assign empty    = !ovalid_q;
	assign result   = out_q;

	always_comb begin
		push_en   = 1'b0;
		pb        = 8'h00;
		cq_rd     = 1'b0;
		load_stat = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cq_valid) begin
					unique case (cq_cmd.kind)
						sha_pkg::CMD_APPEND: begin
							push_en = 1'b1;
							pb      = cq_cmd.data_byte;
							cq_rd   = 1'b1;
						end
						sha_pkg::CMD_FINISH: cq_rd = 1'b1;
						sha_pkg::CMD_OVERFLOW: begin
							load_stat = out_free;
							cq_rd     = out_free;
						end
						default: cq_rd = 1'b1;
					endcase
				end
			end
			ST_PAD: begin
				if (first_q || cnt_q != 6'd56) begin
					push_en = 1'b1;
					pb      = first_q ? 8'h80 : 8'h00;
				end
			end
			ST_LEN: begin
				push_en = 1'b1;
				pb      = len_q[63:56];
			end
			default: ;
		endcase
	end

	// round datapath; window tap 0 is the current schedule word
	always_comb begin
		s1   = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
		s0   = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
		wnew = s1 + win_q[9] + s0 + win_q[0];
		t1   = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
		     + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + sha_pkg::KROUND[rnd_q]
		     + win_q[0];
		t2   = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
		     + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			word_q <= {word_q[15:0], pb};
			if (cnt_q[1:0] == 2'd3) begin
				for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
				win_q[15] <= {word_q, pb};
			end
			if (cnt_q == 6'd63) begin
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			end
		end
		if (state_q == ST_COMP) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= wnew;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (state_q == ST_IDLE && cq_valid && cq_cmd.kind == sha_pkg::CMD_FINISH) begin
			len_q <= {msg_q, 3'b000};
		end else if (state_q == ST_LEN) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (load_stat) begin
			out_q.digest_word <= '0;
			out_q.word_index  <= '0;
			out_q.last_word   <= 1'b1;
			out_q.status      <= sha_pkg::STATUS_OVERFLOW;
		end else if (state_q == ST_OUT && out_free) begin
			out_q.digest_word <= h_q[idx_q];
			out_q.word_index  <= idx_q;
			out_q.last_word   <= (idx_q == 3'd7);
			out_q.status      <= sha_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ret_q    <= ST_IDLE;
			cnt_q    <= '0;
			rnd_q    <= '0;
			idx_q    <= '0;
			first_q  <= 1'b0;
			ovalid_q <= 1'b0;
			msg_q    <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::IV[i];
		end else begin
			if (load_stat || (state_q == ST_OUT && out_free)) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
			if (push_en) begin
				cnt_q   <= cnt_q + 1'b1;
				first_q <= 1'b0;
				if (state_q == ST_IDLE) begin
					msg_q <= msg_q + 1'b1;
				end
				if (cnt_q == 6'd63) begin
					rnd_q   <= '0;
					ret_q   <= (state_q == ST_LEN) ? ST_OUT : state_q;
					state_q <= ST_COMP;
				end else if (state_q == ST_LEN && cnt_q == 6'd62) begin
					state_q <= ST_LEN;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cq_valid && cq_cmd.kind == sha_pkg::CMD_FINISH) begin
						first_q <= 1'b1;
						msg_q   <= '0;
						state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					if (!first_q && cnt_q == 6'd56) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: ;
				ST_COMP: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FF;
					end
				end
				ST_FF: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					idx_q   <= '0;
					state_q <= ret_q;
				end
				ST_OUT: begin
					if (out_free) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::IV[i];
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/sha256_stream_hasher_core.sv =====
// Append: the back end takes one byte per cycle while idle; every 64th byte starts
// a compression (64 rounds on one round unit, then the feed-forward add).
// Finish: 9 to 72 pad and length bytes at one per cycle, one or two compressions,
// then eight digest beats, one per cycle while pop keeps up.
// The front queue takes one byte per cycle until full while the back compresses.
// Reset loads the initial hash and clears counts and queues; no clearing pass.
module sha256_stream_hasher_core #(
	parameter int CmdDepth = sha_pkg::CMD_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  sha_pkg::in_t  item,
	output logic          empty,
	input  logic          pop,
	output sha_pkg::out_t result
);

	logic          q_full, q_wr, rd_valid, rd;
	sha_pkg::cmd_t wr_cmd, rd_cmd;

	sha_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_full (q_full),
		.q_wr   (q_wr),
		.q_cmd  (wr_cmd)
	);

	sha_cmdq #(.Depth(CmdDepth)) u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_cmd   (wr_cmd),
		.q_full   (q_full),
		.rd_valid (rd_valid),
		.rd       (rd),
		.rd_cmd   (rd_cmd)
	);

	sha_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cq_valid (rd_valid),
		.cq_cmd   (rd_cmd),
		.cq_rd    (rd),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

	logic          clk;
	logic          arst_n;
	logic          push;
	logic          full;
	sha_pkg::in_t  item;
	logic          empty;
	logic          pop;
	sha_pkg::out_t result;

	sha256_stream_hasher_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// digest predictor state
	logic [31:0] hash_st [8];
	logic [7:0]  blk_buf [64];
	logic [5:0]  blk_fill;
	logic [60:0] msg_len;

	sha_pkg::in_t  pending_beats [$];
	sha_pkg::out_t digest_q [$];
	int   fail_count;
	int   hold_gap;
	int   long_hold;
	int   idle_cycles;

	function automatic logic [31:0] rotr(logic [31:0] v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		int t;
		for (t = 0; t < 16; t++)
			w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
		for (t = 16; t < 64; t++) begin
			s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = s1 + w[t-7] + s0 + w[t-16];
		end
		{a, b, c, d, e, f, g, h} = {hash_st[0], hash_st[1], hash_st[2], hash_st[3],
			hash_st[4], hash_st[5], hash_st[6], hash_st[7]};
		for (t = 0; t < 64; t++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ sha_pkg::KROUND[t] + w[t];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
		hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
	endtask

	task automatic hasher_restart();
		int i;
		for (i = 0; i < 8; i++)
			hash_st[i] = sha_pkg::IV[i];
		blk_fill = '0;
		msg_len = '0;
	endtask

	task automatic predict_digest(sha_pkg::in_t beat);
		sha_pkg::out_t r;
		logic [63:0] bits;
		int p, i;
		if (beat.op == sha_pkg::OP_APPEND) begin
			if (msg_len == '1) begin
				r = '{digest_word: '0, word_index: '0, last_word: 1'b1,
					status: sha_pkg::STATUS_OVERFLOW};
				digest_q.push_back(r);
			end else begin
				blk_buf[blk_fill] = beat.data_byte;
				msg_len++;
				blk_fill++;
				if (blk_fill == 0)
					compress();
			end
		end else begin
			bits = {msg_len, 3'b000};
			p = blk_fill;
			blk_buf[p] = 8'h80;
			p++;
			if (p > 56) begin
				while (p < 64)
					blk_buf[p++] = 8'h00;
				compress();
				p = 0;
			end
			while (p < 56)
				blk_buf[p++] = 8'h00;
			for (i = 0; i < 8; i++)
				blk_buf[56+i] = bits[(7-i)*8 +: 8];
			compress();
			for (i = 0; i < 8; i++) begin
				r = '{digest_word: hash_st[i], word_index: i[2:0],
					last_word: (i == 7), status: sha_pkg::STATUS_OK};
				digest_q.push_back(r);
			end
			hasher_restart();
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		fail_count++;
	endtask

	task automatic add_msg(int len, bit fin);
		sha_pkg::in_t b;
		int i;
		for (i = 0; i < len; i++) begin
			b.op = sha_pkg::OP_APPEND;
			b.data_byte = 8'($urandom);
			pending_beats.push_back(b);
		end
		if (fin) begin
			b.op = sha_pkg::OP_FINISH;
			b.data_byte = 8'($urandom);
			pending_beats.push_back(b);
		end
	endtask

	// driver; the head of pending_beats is the beat on offer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
			hold_gap <= 0;
		end else begin
			if (push && !full) begin
				predict_digest(item);
				void'(pending_beats.pop_front());
			end
			if (push && full) begin
				// keep offering
			end else if (hold_gap > 0) begin
				push <= 1'b0;
				hold_gap <= hold_gap - 1;
			end else if (pending_beats.size() > 0) begin
				item <= pending_beats[0];
				push <= 1'b1;
				hold_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		sha_pkg::out_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			long_hold <= 0;
		end else begin
			if (pop && !empty) begin
				if (digest_q.size() == 0) begin
					report_mismatch("unexpected beat", result.digest_word, '0);
				end else begin
					want = digest_q.pop_front();
					if (result.digest_word !== want.digest_word)
						report_mismatch("digest_word", result.digest_word, want.digest_word);
					if (result.word_index !== want.word_index)
						report_mismatch("word_index", result.word_index, want.word_index);
					if (result.last_word !== want.last_word)
						report_mismatch("last_word", result.last_word, want.last_word);
					if (result.status !== want.status)
						report_mismatch("status", result.status, want.status);
				end
			end
			if (long_hold > 0) begin
				pop <= 1'b0;
				long_hold <= long_hold - 1;
			end else if ($urandom_range(0, 40) == 0) begin
				pop <= 1'b0;
				long_hold <= 400;
			end else if ($urandom_range(0, 2) == 0) begin
				pop <= 1'b1;
			end else begin
				pop <= ($urandom_range(0, 11) == 0);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 3000) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		fail_count = 0;
		idle_cycles = 0;
		hasher_restart();
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// directed: empty message, byte extremes, lengths 56/64
		add_msg(0, 1);
		pending_beats.push_back('{op: sha_pkg::OP_APPEND, data_byte: 8'h00});
		pending_beats.push_back('{op: sha_pkg::OP_APPEND, data_byte: 8'hff});
		pending_beats.push_back('{op: sha_pkg::OP_FINISH, data_byte: 8'hff});
		add_msg(56, 1);
		add_msg(64, 1);
		// one short random message
		add_msg($urandom_range(0, 5), 1);
		// the 2^61-1 byte limit cannot be reached in simulation
		wait (pending_beats.size() == 0 && !push);
		wait (digest_q.size() == 0);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
